// ===== src/brapq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range add / point query package
// Sizes, operation codes and the control structs shared by the block's files.
// ----------------------------------------------------------------------------
package brapq_pkg;

  localparam int MAX_ELEMENTS = 256;
  // The block size must be a power of two so that an index splits into
  // block number and offset by bit selection.
  localparam int BLOCK_SIZE   = 16;
  localparam int NUM_BLOCKS   = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int OFF_W = $clog2(BLOCK_SIZE);
  localparam int BLK_W = IDX_W - OFF_W;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int VAL_W = 64;
  localparam int OP_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic capture;
    logic decode;
    logic load_wr;
    logic walk_step;
    logic set_sum;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic bad;
    logic walk_done;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/brapq_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
interface brapq_in_if;
  logic                          valid;
  logic                          ready;
  logic [brapq_pkg::OP_W-1:0]    operation;
  logic [brapq_pkg::IDX_W-1:0]   first_index;
  logic [brapq_pkg::IDX_W-1:0]   last_index;
  logic signed [brapq_pkg::VAL_W-1:0] value;

  modport source (output valid, operation, first_index, last_index, value, input ready);
  modport sink   (input valid, operation, first_index, last_index, value, output ready);
endinterface
`default_nettype wire

// ===== src/brapq_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface brapq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [brapq_pkg::VAL_W-1:0] query_value;
  logic                               status;

  modport source (output valid, query_value, status, input ready);
  modport sink   (input valid, query_value, status, output ready);
endinterface
`default_nettype wire

// ===== src/block_range_add_point_query.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block range add with point query
// 256 signed 64-bit elements in blocks of 16, each block with a pending tag.
// ----------------------------------------------------------------------------
// One item is handled at a time, and every item gives exactly one result item.
// A load, an unused operation or a rejected item goes from decode straight to
// the response state; a query passes through a wait state, and a range add
// through the walker. The block is ready again as soon as the result enters
// the output register. The walker in the element memory does the add: each
// element of a partly covered block costs one step (read, then written back
// incremented in the following cycle, overlapped with the next read), and each
// fully covered block costs one step for its tag, so at most
// 2*(BLOCK_SIZE-1) + NUM_BLOCKS - 2 steps. The output register lets a new item
// be taken while an earlier result waits. Elements hold nothing until loaded.
module block_range_add_point_query (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [brapq_pkg::CNT_W-1:0]   cfg_wdata_i,
  brapq_in_if.sink                           item_i,
  brapq_out_if.source                        result_o
);

  brapq_pkg::cmd_t cmd;
  brapq_pkg::sts_t sts;

  brapq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  brapq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .operation_i   (item_i.operation),
    .first_index_i (item_i.first_index),
    .last_index_i  (item_i.last_index),
    .value_i       (item_i.value),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .query_value_o (result_o.query_value),
    .status_o      (result_o.status)
  );

endmodule
`default_nettype wire

// ===== src/brapq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range add datapath
// Element memory, block tags, length register, range walker and result regs.
// ----------------------------------------------------------------------------
module brapq_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [brapq_pkg::CNT_W-1:0]       cfg_wdata_i,
  input  wire logic [brapq_pkg::OP_W-1:0]        operation_i,
  input  wire logic [brapq_pkg::IDX_W-1:0]       first_index_i,
  input  wire logic [brapq_pkg::IDX_W-1:0]       last_index_i,
  input  wire logic [brapq_pkg::VAL_W-1:0]       value_i,
  input  wire brapq_pkg::cmd_t                   cmd_i,
  output brapq_pkg::sts_t                        sts_o,
  output logic [brapq_pkg::VAL_W-1:0]            query_value_o,
  output logic                                   status_o
);

  localparam int IW = brapq_pkg::IDX_W;
  localparam int OW = brapq_pkg::OFF_W;
  localparam int CW = brapq_pkg::CNT_W;
  localparam int VW = brapq_pkg::VAL_W;

  logic [CW-1:0]      count_q;
  brapq_pkg::op_e     op_q;
  logic [IW-1:0]      first_q, last_q;
  logic [VW-1:0]      value_q;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic [VW-1:0]      elem_mem_q [brapq_pkg::MAX_ELEMENTS];
  logic [VW-1:0]      rd_data_q;
  logic               wr_pend_q;
  logic [IW-1:0]      wr_addr_q;
  logic [VW-1:0]      tag_q [brapq_pkg::NUM_BLOCKS];
  logic [VW-1:0]      result_q;
  logic               status_q;
  logic [VW-1:0]      out_value_q;
  logic               out_status_q;

  logic [CW-1:0]      used_len;
  logic               idx_bad, range_bad, bad;
  logic [brapq_pkg::BLK_W-1:0] first_blk, ptr_blk, last_blk;
  logic [OW-1:0]      ptr_off, last_off;
  logic               full_block;
  logic               mem_we;
  logic [IW-1:0]      mem_wa, mem_ra;
  logic [VW-1:0]      mem_wd;

  // A count above the array size is limited to the array size.
  assign used_len  = (count_q > CW'(brapq_pkg::MAX_ELEMENTS)) ?
                     CW'(brapq_pkg::MAX_ELEMENTS) : count_q;
  assign idx_bad   = {1'b0, first_q} >= used_len;
  assign range_bad = (first_q > last_q) || ({1'b0, last_q} >= used_len);

  always_comb begin
    unique case (op_q) inside
      brapq_pkg::OP_LOAD, brapq_pkg::OP_QUERY: bad = idx_bad;
      brapq_pkg::OP_ADD:                       bad = range_bad;
      default:                                 bad = 1'b0;
    endcase
  end

  assign first_blk = first_q[IW-1:OW];
  assign ptr_blk   = ptr_q[IW-1:OW];
  assign ptr_off   = ptr_q[OW-1:0];
  assign last_blk  = last_q[IW-1:OW];
  assign last_off  = last_q[OW-1:0];

  // A block that the range covers entirely only has its tag bumped.
  assign full_block = (ptr_off == '0) && ((last_blk > ptr_blk) || (last_off == '1));
  assign ptr_d      = full_block ? ptr_q + CW'(brapq_pkg::BLOCK_SIZE) : ptr_q + CW'(1);

  assign mem_ra = cmd_i.walk_step ? ptr_q[IW-1:0] : first_q;
  assign mem_we = cmd_i.load_wr | wr_pend_q;
  assign mem_wa = cmd_i.load_wr ? first_q : wr_addr_q;
  assign mem_wd = cmd_i.load_wr ? value_q - tag_q[first_blk] : rd_data_q + value_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      elem_mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= elem_mem_q[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= brapq_pkg::op_e'(operation_i);
      first_q <= first_index_i;
      last_q  <= last_index_i;
      value_q <= value_i;
      ptr_q   <= {1'b0, first_index_i};
    end else if (cmd_i.walk_step) begin
      ptr_q   <= ptr_d;
    end
    wr_addr_q <= ptr_q[IW-1:0];
    if (cmd_i.decode) begin
      result_q <= '0;
      status_q <= bad;
    end else if (cmd_i.set_sum) begin
      result_q <= rd_data_q + tag_q[first_blk];
    end
    if (cmd_i.out_load) begin
      out_value_q  <= result_q;
      out_status_q <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= CW'(brapq_pkg::MAX_ELEMENTS);
      wr_pend_q <= 1'b0;
      for (int b = 0; b < brapq_pkg::NUM_BLOCKS; b++) begin
        tag_q[b] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      // The element read this cycle is written back, incremented, next cycle.
      wr_pend_q <= cmd_i.walk_step && !full_block;
      if (cmd_i.walk_step && full_block) begin
        tag_q[ptr_blk] <= tag_q[ptr_blk] + value_q;
      end
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.bad       = bad;
  assign sts_o.walk_done = ptr_q > {1'b0, last_q};

  assign query_value_o = out_value_q;
  assign status_o      = out_status_q;

endmodule
`default_nettype wire

// ===== src/brapq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Range add controller
// Sequences one item at a time and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module brapq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire brapq_pkg::sts_t  sts_i,
  output brapq_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_QWAIT,
    ST_WALK,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        if (sts_i.bad) begin
          state_d = ST_RESP;
        end else begin
          unique case (sts_i.op)
            brapq_pkg::OP_LOAD: begin
              cmd_o.load_wr = 1'b1;
              state_d       = ST_RESP;
            end
            brapq_pkg::OP_QUERY: state_d = ST_QWAIT;
            brapq_pkg::OP_ADD:   state_d = ST_WALK;
            default:             state_d = ST_RESP;
          endcase
        end
      end
      ST_QWAIT: begin
        cmd_o.set_sum = 1'b1;
        state_d       = ST_RESP;
      end
      ST_WALK: begin
        if (sts_i.walk_done) begin
          state_d = ST_RESP;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DECODE))
    else $error("accepted item not decoded next cycle");

  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && sts_i.walk_done) |=> (state_q == ST_RESP))
    else $error("range walk did not finish");

  a_qwait_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QWAIT) |-> ($past(state_q) == ST_DECODE))
    else $error("query wait entered from wrong state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");

endmodule
`default_nettype wire
